### rtl/assert_macros.svh
// Assertion macros shared by the RTL files. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/hts_pkg.sv
`default_nettype none

package hts_pkg;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DOT0  = 8'hC2;
  localparam logic [7:0] CH_DOT1  = 8'hB7;
  localparam logic [7:0] CH_BTICK = 8'h60;
  localparam logic [7:0] CH_APOS  = 8'h27;

  localparam logic [20:0] CP_MAX   = 21'h10FFFF;
  localparam logic [20:0] CP_LQUOT = 21'h002018;
  localparam logic [20:0] CP_RQUOT = 21'h002019;

  localparam int unsigned MAX_BYTES = 4;

  // Everything one input byte produces: up to four output bytes and the end flag.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      done;
  } hts_group_t;

endpackage

`default_nettype wire

### rtl/hts_in_if.sv
`default_nettype none

interface hts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

### rtl/hts_out_if.sv
`default_nettype none

interface hts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_of_run;
  logic       text_done;

  modport source (output valid, output out_byte, output byte_valid, output last_of_run,
                  output text_done, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input last_of_run,
                input text_done, output ready);
endinterface

`default_nettype wire

### rtl/hts_front.sv
`default_nettype none

module hts_front (
  input  logic               clk,
  input  logic               rst,
  hts_in_if.sink             html,
  output hts_pkg::hts_group_t grp,
  output logic               grp_valid,
  input  logic               grp_ready
);
  import hts_pkg::*;

  typedef enum logic [1:0] {MODE_PLAIN, MODE_TAG, MODE_ENTITY} mode_t;
  typedef enum logic [1:0] {FORM_NAMED, FORM_HASH, FORM_DEC, FORM_HEX} form_t;

  localparam logic [2:0] LEN_LONG   = 3'd4;
  localparam logic [2:0] LEN_FROZEN = 3'd7;

  mode_t            mode, mode_next;
  form_t            form, form_next;
  logic             para, para_next;
  logic [2:0][7:0]  name, name_next;
  logic [2:0]       len, len_next;
  logic [20:0]      cp, cp_next;

  logic [7:0]       c;
  logic             accept;
  logic [2:0][7:0]  kept_name;
  logic [2:0]       kept_len;
  logic             dec_ok, hex_ok, digit_ok;
  logic [3:0]       dval;
  logic [24:0]      acc, sum;
  logic [20:0]      cp_sat;
  logic [MAX_BYTES-1:0][7:0] enc;
  logic [2:0]       enc_cnt;
  logic             is_li, is_p, is_ul, is_lt, is_gt, is_amp;
  logic [MAX_BYTES-1:0][7:0] obytes;
  logic [2:0]       ocnt;

  assign c      = html.in_byte;
  assign accept = html.valid && html.ready;

  assign html.ready = grp_ready;
  assign grp_valid  = html.valid && ((ocnt != 3'd0) || html.end_of_text);
  assign grp.bytes  = obytes;
  assign grp.cnt    = ocnt;
  assign grp.done   = html.end_of_text;

  always_comb begin
    kept_name = name;
    kept_len  = LEN_LONG;
    if (len < 3'd3) begin
      kept_name[len[1:0]] = c;
      kept_len = len + 3'd1;
    end
  end

  assign dec_ok   = (c >= "0") && (c <= "9");
  assign hex_ok   = dec_ok || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  assign digit_ok = (form == FORM_HEX) ? hex_ok : dec_ok;
  assign dval     = dec_ok ? c[3:0] : c[3:0] + 4'd9;
  assign acc      = (form == FORM_HEX) ? {cp, 4'b0000}
                                       : {1'b0, cp, 3'b000} + {3'b000, cp, 1'b0};
  assign sum      = acc + {21'd0, dval};
  assign cp_sat   = (sum > {4'd0, CP_MAX}) ? CP_MAX : sum[20:0];

  always_comb begin
    enc     = '0;
    enc_cnt = 3'd0;
    if (cp == 21'd0) begin
      enc_cnt = 3'd0;
    end else if (cp == CP_LQUOT) begin
      enc[0]  = CH_BTICK;
      enc_cnt = 3'd1;
    end else if (cp == CP_RQUOT) begin
      enc[0]  = CH_APOS;
      enc_cnt = 3'd1;
    end else if (cp < 21'h80) begin
      enc[0]  = cp[7:0];
      enc_cnt = 3'd1;
    end else if (cp < 21'h800) begin
      enc[0]  = {3'b110, cp[10:6]};
      enc[1]  = {2'b10, cp[5:0]};
      enc_cnt = 3'd2;
    end else if (cp < 21'h10000) begin
      enc[0]  = {4'b1110, cp[15:12]};
      enc[1]  = {2'b10, cp[11:6]};
      enc[2]  = {2'b10, cp[5:0]};
      enc_cnt = 3'd3;
    end else begin
      enc[0]  = {5'b11110, cp[20:18]};
      enc[1]  = {2'b10, cp[17:12]};
      enc[2]  = {2'b10, cp[11:6]};
      enc[3]  = {2'b10, cp[5:0]};
      enc_cnt = 3'd4;
    end
  end

  assign is_li  = (len == 3'd2) && (name[0] == "l") && (name[1] == "i");
  assign is_p   = (len == 3'd1) && (name[0] == "p");
  assign is_ul  = (len == 3'd2) && (name[0] == "u") && (name[1] == "l");
  assign is_lt  = (len == 3'd2) && (name[0] == "l") && (name[1] == "t");
  assign is_gt  = (len == 3'd2) && (name[0] == "g") && (name[1] == "t");
  assign is_amp = (len == 3'd3) && (name[0] == "a") && (name[1] == "m") && (name[2] == "p");

  always_comb begin
    mode_next = mode;
    form_next = form;
    para_next = para;
    name_next = name;
    len_next  = len;
    cp_next   = cp;
    obytes    = '0;
    ocnt      = 3'd0;
    unique case (mode)
      MODE_TAG: begin
        if (c == CH_GT) begin
          mode_next = MODE_PLAIN;
          if (is_li) begin
            para_next = 1'b0;
            if (!para) begin
              obytes = {CH_SP, CH_DOT1, CH_DOT0, CH_NL};
              ocnt   = 3'd4;
            end else begin
              obytes = {8'h00, CH_SP, CH_DOT1, CH_DOT0};
              ocnt   = 3'd3;
            end
          end else if (is_p || is_ul) begin
            para_next = 1'b1;
            if (!para) begin
              obytes[0] = CH_NL;
              ocnt      = 3'd1;
            end
          end
        end else begin
          name_next = kept_name;
          len_next  = kept_len;
        end
      end
      MODE_ENTITY: begin
        if (c == CH_SEMI) begin
          mode_next = MODE_PLAIN;
          if (form != FORM_NAMED) begin
            obytes = enc;
            ocnt   = enc_cnt;
          end else if (is_lt) begin
            obytes[0] = CH_LT;
            ocnt      = 3'd1;
          end else if (is_gt) begin
            obytes[0] = CH_GT;
            ocnt      = 3'd1;
          end else if (is_amp) begin
            obytes[0] = CH_AMP;
            ocnt      = 3'd1;
          end
        end else begin
          unique case (form)
            FORM_NAMED: begin
              if ((len == 3'd0) && (c == CH_HASH)) begin
                form_next = FORM_HASH;
              end else begin
                name_next = kept_name;
                len_next  = kept_len;
              end
            end
            FORM_HASH: begin
              if (dec_ok) begin
                form_next = FORM_DEC;
                cp_next   = {17'd0, dval};
              end else if ((c == "x") || (c == "X")) begin
                form_next = FORM_HEX;
                cp_next   = 21'd0;
              end else begin
                form_next = FORM_DEC;
                cp_next   = 21'd0;
                len_next  = LEN_FROZEN;
              end
            end
            default: begin
              if (len != LEN_FROZEN) begin
                if (!digit_ok) begin
                  len_next = LEN_FROZEN;
                end else begin
                  cp_next = cp_sat;
                end
              end
            end
          endcase
        end
      end
      default: begin
        if (c == CH_LT) begin
          mode_next = MODE_TAG;
          name_next = '0;
          len_next  = 3'd0;
          cp_next   = 21'd0;
          form_next = FORM_NAMED;
        end else if (c == CH_AMP) begin
          mode_next = MODE_ENTITY;
          para_next = 1'b0;
          name_next = '0;
          len_next  = 3'd0;
          cp_next   = 21'd0;
          form_next = FORM_NAMED;
        end else begin
          obytes[0] = c;
          ocnt      = 3'd1;
          para_next = 1'b0;
        end
      end
    endcase
    if (html.end_of_text) begin
      mode_next = MODE_PLAIN;
      para_next = 1'b1;
      name_next = '0;
      len_next  = 3'd0;
      cp_next   = 21'd0;
      form_next = FORM_NAMED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      form <= FORM_NAMED;
      para <= 1'b1;
      name <= '0;
      len  <= 3'd0;
      cp   <= 21'd0;
    end else if (accept) begin
      mode <= mode_next;
      form <= form_next;
      para <= para_next;
      name <= name_next;
      len  <= len_next;
      cp   <= cp_next;
    end
  end

endmodule

`default_nettype wire

### rtl/hts_queue.sv
`default_nettype none

module hts_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  hts_pkg::hts_group_t push_data,
  input  logic                push_valid,
  output logic                push_ready,
  output hts_pkg::hts_group_t pop_data,
  output logic                pop_valid,
  input  logic                pop_ready
);
  import hts_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  hts_group_t     store [DEPTH];
  logic [PW-1:0]  wptr, rptr;
  logic [CW-1:0]  count;
  logic           push, pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = store[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(q_count_bound, count <= CW'(DEPTH), "queue count beyond depth")
  `ASSERT_NEXT(q_count_up, push && !pop, count == $past(count) + 1'b1, "queue count missed a push")
  `ASSERT_NEXT(q_count_down, pop && !push, count == $past(count) - 1'b1, "queue count missed a pop")

endmodule

`default_nettype wire

### rtl/hts_back.sv
`default_nettype none

module hts_back (
  input  logic                clk,
  input  logic                rst,
  input  hts_pkg::hts_group_t grp,
  input  logic                grp_valid,
  output logic                grp_ready,
  hts_out_if.source           plain
);
  import hts_pkg::*;

  `include "assert_macros.svh"

  hts_group_t cur;
  logic       have;
  logic [1:0] idx;
  logic       is_last, fire, advance;

  assign is_last   = (cur.cnt == 3'd0) || ({1'b0, idx} == cur.cnt - 3'd1);
  assign fire      = plain.valid && plain.ready;
  assign advance   = !have || (fire && is_last);
  assign grp_ready = advance;

  assign plain.valid       = have;
  assign plain.out_byte    = (cur.cnt == 3'd0) ? 8'h00 : cur.bytes[idx];
  assign plain.byte_valid  = (cur.cnt != 3'd0);
  assign plain.last_of_run = is_last;
  assign plain.text_done   = is_last && cur.done;

  always_ff @(posedge clk) begin
    if (advance && grp_valid) begin
      cur <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      idx  <= 2'd0;
    end else if (advance) begin
      have <= grp_valid;
      idx  <= 2'd0;
    end else if (fire) begin
      idx <= idx + 2'd1;
    end
  end

  `ASSERT_IMPLIES(b_bare_marker, have && (cur.cnt == 3'd0), cur.done,
                  "bare end marker without end of text")
  `ASSERT_IMPLIES(b_done_last, plain.valid && plain.text_done, plain.last_of_run,
                  "end of text flagged before the last item of its run")
  `ASSERT_ALWAYS(b_cnt_range, !have || (cur.cnt <= 3'd4), "too many bytes in one run")

endmodule

`default_nettype wire

### rtl/html_text_stripper.sv
// Channel  Role    Payload
// html     sink    in_byte[7:0], end_of_text
// plain    source  out_byte[7:0], byte_valid, last_of_run, text_done
//
// One input item is taken per cycle while the queue between parser and emitter has room.
// Each input item yields zero to four output items, sent one per cycle by the emitter while plain is ready.
// Sustained rate is one input per cycle when each input yields at most one output item and plain is ready.
// Reset is synchronous; parser state returns to plain text with a paragraph open.
// A stall on plain fills the queue of QUEUE_DEPTH runs, then lowers html.ready.
`default_nettype none

module html_text_stripper #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  hts_in_if.sink    html,
  hts_out_if.source plain
);
  import hts_pkg::*;

  hts_group_t f_grp, b_grp;
  logic       f_valid, f_ready, b_valid, b_ready;

  hts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .html      (html),
    .grp       (f_grp),
    .grp_valid (f_valid),
    .grp_ready (f_ready)
  );

  hts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (f_grp),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_data   (b_grp),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready)
  );

  hts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .grp       (b_grp),
    .grp_valid (b_valid),
    .grp_ready (b_ready),
    .plain     (plain)
  );

endmodule

`default_nettype wire

### tb/html_text_stripper_tb.sv
module html_text_stripper_tb;
  import hts_pkg::*;

  typedef enum logic [1:0] {MODE_PLAIN, MODE_TAG, MODE_ENTITY} strip_mode_e;
  typedef enum logic [1:0] {FORM_NAMED, FORM_HASH, FORM_DEC, FORM_HEX} num_form_e;

  localparam logic [2:0] NAME_LONG    = 3'd4;
  localparam logic [2:0] DIGITS_ENDED = 3'd7;
  localparam int RANDOM_ITEMS   = 200;
  localparam int WATCHDOG_LIMIT = 300;
  localparam int DRAIN_CYCLES   = 16;
  localparam int N_DIRECTED     = 26;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       text_done;
  } plain_item_t;

  typedef struct packed {
    logic [7:0]  in_byte;
    logic        eot;
    logic        typed;
    plain_item_t want;
  } stim_row_t;

  localparam plain_item_t NO_WANT = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic steady = 1'b0;
  stim_row_t pending_row = '0;
  int mismatches = 0;
  int stalled_cycles = 0;

  strip_mode_e mode;
  num_form_e   form;
  logic        para_open;
  logic [7:0]  name_buf [3];
  logic [2:0]  name_len;
  logic [20:0] cp_acc;
  logic [7:0]  run_bytes [$];
  plain_item_t expected_text [$];
  logic [7:0]  token_q [$];

  // Typed expectations stand only where the answer is obvious from the item alone.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{8'h00,   1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{8'hFF,   1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
    '{CH_LT,   1'b0, 1'b0, NO_WANT},
    '{"l",     1'b0, 1'b0, NO_WANT},
    '{"i",     1'b0, 1'b0, NO_WANT},
    '{CH_GT,   1'b0, 1'b0, NO_WANT},
    '{CH_AMP,  1'b0, 1'b0, NO_WANT},
    '{CH_HASH, 1'b0, 1'b0, NO_WANT},
    '{"0",     1'b0, 1'b0, NO_WANT},
    '{CH_SEMI, 1'b0, 1'b0, NO_WANT},
    '{CH_AMP,  1'b0, 1'b0, NO_WANT},
    '{"l",     1'b0, 1'b0, NO_WANT},
    '{"t",     1'b0, 1'b0, NO_WANT},
    '{CH_SEMI, 1'b0, 1'b0, NO_WANT},
    '{CH_LT,   1'b0, 1'b0, NO_WANT},
    '{"p",     1'b0, 1'b0, NO_WANT},
    '{CH_GT,   1'b0, 1'b0, NO_WANT},
    '{CH_GT,   1'b0, 1'b1, '{CH_GT, 1'b1, 1'b1, 1'b0}},
    '{CH_SEMI, 1'b0, 1'b0, NO_WANT},
    '{CH_AMP,  1'b0, 1'b0, NO_WANT},
    '{"a",     1'b0, 1'b0, NO_WANT},
    '{"m",     1'b0, 1'b0, NO_WANT},
    '{"p",     1'b0, 1'b0, NO_WANT},
    '{CH_SEMI, 1'b0, 1'b0, NO_WANT},
    '{"q",     1'b1, 1'b1, '{"q", 1'b1, 1'b1, 1'b1}},
    '{CH_LT,   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}}
  };

  hts_in_if  html ();
  hts_out_if plain ();

  html_text_stripper DUT (
    .clk   (clk),
    .rst   (rst),
    .html  (html),
    .plain (plain)
  );

  always #1 clk = ~clk;

  function automatic void emit(logic [7:0] b);
    if (run_bytes.size() < MAX_BYTES) begin
      run_bytes = {run_bytes, b};
    end
  endfunction

  function automatic void want_item(plain_item_t it);
    expected_text = {expected_text, it};
  endfunction

  function automatic void add_byte(logic [7:0] b);
    token_q = {token_q, b};
  endfunction

  function automatic void clear_name();
    name_buf = '{default: 8'h00};
    name_len = 3'd0;
    cp_acc = '0;
    form = FORM_NAMED;
  endfunction

  function automatic void strip_reset();
    mode = MODE_PLAIN;
    para_open = 1'b1;
    clear_name();
  endfunction

  function automatic void keep_name_char(logic [7:0] c);
    if (name_len < 3'd3) begin
      name_buf[name_len] = c;
      name_len++;
    end else begin
      name_len = NAME_LONG;
    end
  endfunction

  function automatic logic name_is(string s);
    int i;
    if (name_len != s.len()) return 1'b0;
    for (i = 0; i < s.len(); i++) begin
      if (name_buf[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int digit_of(logic [7:0] c, logic hex);
    if (c >= "0" && c <= "9") return c - "0";
    if (hex && c >= "a" && c <= "f") return c - "a" + 10;
    if (hex && c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void emit_code_point(logic [20:0] cp);
    if (cp == '0) return;
    if (cp == CP_LQUOT) begin
      emit(CH_BTICK);
    end else if (cp == CP_RQUOT) begin
      emit(CH_APOS);
    end else if (cp < 21'h80) begin
      emit(cp[7:0]);
    end else if (cp < 21'h800) begin
      emit({3'b110, cp[10:6]});
      emit({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      emit({4'b1110, cp[15:12]});
      emit({2'b10, cp[11:6]});
      emit({2'b10, cp[5:0]});
    end else begin
      emit({5'b11110, cp[20:18]});
      emit({2'b10, cp[17:12]});
      emit({2'b10, cp[11:6]});
      emit({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void close_tag();
    if (name_is("li")) begin
      if (!para_open) emit(CH_NL);
      emit(CH_DOT0);
      emit(CH_DOT1);
      emit(CH_SP);
      para_open = 1'b0;
    end else if (name_is("p") || name_is("ul")) begin
      if (!para_open) emit(CH_NL);
      para_open = 1'b1;
    end
  endfunction

  function automatic void close_entity();
    if (form != FORM_NAMED) begin
      emit_code_point(cp_acc);
    end else if (name_is("lt")) begin
      emit(CH_LT);
    end else if (name_is("gt")) begin
      emit(CH_GT);
    end else if (name_is("amp")) begin
      emit(CH_AMP);
    end
  endfunction

  function automatic void entity_char(logic [7:0] c);
    int d;
    logic [31:0] acc;
    case (form)
      FORM_NAMED: begin
        if (name_len == 3'd0 && c == CH_HASH) form = FORM_HASH;
        else keep_name_char(c);
      end
      FORM_HASH: begin
        d = digit_of(c, 1'b0);
        if (d >= 0) begin
          form = FORM_DEC;
          cp_acc = 21'(d);
        end else if (c == "x" || c == "X") begin
          form = FORM_HEX;
          cp_acc = '0;
        end else begin
          form = FORM_DEC;
          cp_acc = '0;
          name_len = DIGITS_ENDED;
        end
      end
      default: begin
        if (name_len != DIGITS_ENDED) begin
          d = digit_of(c, form == FORM_HEX);
          if (d < 0) begin
            name_len = DIGITS_ENDED;
          end else begin
            acc = 32'(cp_acc) * ((form == FORM_HEX) ? 32'd16 : 32'd10) + 32'(d);
            cp_acc = (acc > 32'(CP_MAX)) ? CP_MAX : acc[20:0];
          end
        end
      end
    endcase
  endfunction

  function automatic void strip_byte(logic [7:0] c, logic eot);
    run_bytes.delete();
    case (mode)
      MODE_TAG: begin
        if (c == CH_GT) begin
          close_tag();
          mode = MODE_PLAIN;
        end else begin
          keep_name_char(c);
        end
      end
      MODE_ENTITY: begin
        if (c == CH_SEMI) begin
          close_entity();
          mode = MODE_PLAIN;
        end else begin
          entity_char(c);
        end
      end
      default: begin
        if (c == CH_LT) begin
          clear_name();
          mode = MODE_TAG;
        end else if (c == CH_AMP) begin
          clear_name();
          mode = MODE_ENTITY;
          para_open = 1'b0;
        end else begin
          emit(c);
          para_open = 1'b0;
        end
      end
    endcase
    if (eot) strip_reset();
  endfunction

  function automatic void queue_run(logic eot);
    int k;
    int n;
    n = run_bytes.size();
    if (n == 0 && eot) begin
      want_item('{8'h00, 1'b0, 1'b1, 1'b1});
    end
    for (k = 0; k < n; k++) begin
      want_item('{run_bytes[k], 1'b1, k == n - 1, (k == n - 1) && eot});
    end
  endfunction

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] name_noise();
    string pool;
    pool = "lipuam<&;#x";
    if ($urandom_range(2) == 0) return 8'($urandom_range(255));
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  function automatic void make_token();
    int unsigned pick;
    int unsigned v;
    int i;
    string digits;
    logic hex;
    token_q.delete();
    pick = $urandom_range(99);
    if (pick < 30) begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(3) == 0) add_byte(8'($urandom_range(255)));
        else add_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
    end else if (pick < 50) begin
      add_byte(CH_LT);
      case ($urandom_range(8))
        0, 1: add_text("li");
        2:    add_text("p");
        3:    add_text("ul");
        4:    add_text("LI");
        5:    add_text("lip");
        6:    add_text("div");
        default: repeat ($urandom_range(0, 5)) add_byte(name_noise());
      endcase
      add_byte(CH_GT);
    end else if (pick < 62) begin
      add_byte(CH_AMP);
      case ($urandom_range(7))
        0: add_text("lt");
        1: add_text("gt");
        2: add_text("amp");
        3: add_text("am");
        4: add_text("ampx");
        5: ;
        default: repeat ($urandom_range(1, 4)) add_byte(name_noise());
      endcase
      add_byte(CH_SEMI);
    end else if (pick < 90) begin
      hex = 1'($urandom_range(1));
      case ($urandom_range(9))
        0: v = 0;
        1: v = 32'h2018;
        2: v = 32'h2019;
        3: v = $urandom_range(1, 32'h7F);
        4: v = $urandom_range(32'h80, 32'h7FF);
        5: v = $urandom_range(32'h800, 32'hFFFF);
        6: v = $urandom_range(32'h10000, 32'h10FFFF);
        7: v = $urandom | 32'h0020_0000;
        default: v = $urandom_range(1, 32'h10FFFF);
      endcase
      digits = hex ? $sformatf("%0h", v) : $sformatf("%0d", v);
      if ($urandom_range(9) == 0) digits = "";
      else if ($urandom_range(9) == 0) digits = {"0", digits};
      add_byte(CH_AMP);
      add_byte(CH_HASH);
      if (hex) add_byte($urandom_range(1) ? "x" : "X");
      for (i = 0; i < digits.len(); i++) begin
        if (digits[i] >= "a" && digits[i] <= "f" && $urandom_range(1)) begin
          add_byte(digits[i] - 8'd32);
        end else begin
          add_byte(digits[i]);
        end
      end
      if ($urandom_range(4) == 0) add_text("g7");
      add_byte(CH_SEMI);
    end else begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(255)));
    end
  endfunction

  function automatic void note_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_byte(input stim_row_t row);
    while (!steady && $urandom_range(99) < 34) begin
      html.valid <= 1'b0;
      @(posedge clk);
    end
    html.valid <= 1'b1;
    html.in_byte <= row.in_byte;
    html.end_of_text <= row.eot;
    pending_row <= row;
    @(posedge clk);
    while (!html.ready) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    html.valid <= 1'b0;
    @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    plain_item_t got;
    plain_item_t want;
    if (rst) begin
      strip_reset();
    end else begin
      if (html.valid && html.ready) begin
        strip_byte(html.in_byte, html.end_of_text);
        if (pending_row.typed) want_item(pending_row.want);
        else queue_run(html.end_of_text);
      end
      if (plain.valid && plain.ready) begin
        got = '{plain.out_byte, plain.byte_valid, plain.last_of_run, plain.text_done};
        if (expected_text.size() == 0) begin
          $error("out_byte: expected nothing, got %0h", got.out_byte);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          note_field("out_byte", want.out_byte, got.out_byte);
          note_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
          note_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
          note_field("text_done", 8'(want.text_done), 8'(got.text_done));
        end
      end
    end
  end

  always @(posedge clk) begin
    plain.ready <= steady || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    if ((html.valid && html.ready) || (plain.valid && plain.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("html_text_stripper_tb failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    stim_row_t row;
    int random_items;
    int i;
    logic end_token;
    random_items = 0;
    html.valid <= 1'b0;
    html.in_byte <= 8'h00;
    html.end_of_text <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) send_byte(directed_rows[k]);
    wait_for_drain();

    while (random_items < RANDOM_ITEMS) begin
      make_token();
      end_token = ($urandom_range(99) < 8);
      for (i = 0; i < token_q.size(); i++) begin
        steady = (random_items >= 90 && random_items < 150);
        row = '0;
        row.in_byte = token_q[i];
        row.eot = (end_token && i == token_q.size() - 1) || ($urandom_range(99) < 2);
        send_byte(row);
        random_items++;
      end
    end
    steady = 1'b0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("html_text_stripper_tb passed");
    end else begin
      $display("html_text_stripper_tb failed");
    end
    $finish;
  end

endmodule
